/* sv/fcd_pkg.sv */
`default_nettype none

package fcd_pkg;

	localparam int MaxRows = 1024;
	localparam int MaxCols = 1024;

	localparam int ColW  = $clog2(MaxCols);
	localparam int ColNW = $clog2(MaxCols + 1);
	localparam int RowW  = $clog2(MaxRows + 1);
	localparam int CellW = 10;
	localparam int CfgW  = 11;
	localparam int IdxW  = 3;

	localparam logic [IdxW-1:0] RegGridRows   = IdxW'(0);
	localparam logic [IdxW-1:0] RegGridCols   = IdxW'(1);
	localparam logic [IdxW-1:0] RegFreeCode   = IdxW'(2);
	localparam logic [IdxW-1:0] RegUnknown    = IdxW'(3);
	localparam logic [IdxW-1:0] RegMinUnknown = IdxW'(4);

	localparam int RstRows = (MaxRows < 1024) ? MaxRows : 1024;
	localparam int RstCols = (MaxCols < 1024) ? MaxCols : 1024;

	typedef struct packed {
		logic [7:0] occupancy;
		logic       flush;
	} occ_item_t;

	typedef struct packed {
		logic [CellW-1:0] cell_x;
		logic [CellW-1:0] cell_y;
		logic             is_frontier;
		logic [3:0]       unknown_count;
		logic             last_of_item;
		logic             frame_done;
	} result_t;

	typedef struct packed {
		logic [RowW-1:0]  rows;
		logic [ColNW-1:0] cols;
		logic [7:0]       free_code;
		logic [7:0]       unknown_code;
		logic [3:0]       min_unknown;
	} cfg_t;

	typedef struct packed {
		logic            valid;
		logic [7:0]      top;
		logic [7:0]      mid;
		logic [7:0]      bot;
		logic [ColW-1:0] x;
		logic [RowW-1:0] y;
		logic            end_row;
	} col_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} dec_t;

endpackage

`default_nettype wire

/* sv/fcd_if.sv */
`default_nettype none

interface fcd_occ_if;
	import fcd_pkg::*;
	logic      valid;
	logic      ready;
	occ_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fcd_res_if;
	import fcd_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/fcd_ram.sv */
`default_nettype none

module fcd_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/fcd_line_buf.sv */
`default_nettype none

module fcd_line_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	fcd_occ_if.sink            occ,
	input  wire fcd_pkg::cfg_t cfg,
	input  wire logic          advance,
	output fcd_pkg::col_t      col
);

	import fcd_pkg::*;

	logic [ColW-1:0] x_q;
	logic [RowW-1:0] y_q;
	logic            accept;
	logic            end_row;
	logic            padding;

	logic            valid_s1;
	logic [ColW-1:0] x_s1;
	logic [RowW-1:0] y_s1;
	logic            end_row_s1;
	logic [7:0]      byte_s1;
	logic            byp_s1;
	logic [7:0]      byp_top_s1;
	logic [7:0]      byp_mid_s1;
	logic [7:0]      older_rd;
	logic [7:0]      newer_rd;

	assign occ.ready = !valid_s1 || advance;
	assign accept    = occ.valid && occ.ready;
	assign end_row   = ColNW'(x_q) >= (cfg.cols - ColNW'(1));
	assign padding   = y_q >= cfg.rows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (end_row) begin
					x_q <= '0;
					y_q <= padding ? '0 : y_q + RowW'(1);
				end else begin
					x_q <= x_q + ColW'(1);
				end
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1       <= x_q;
			y_s1       <= y_q;
			end_row_s1 <= end_row;
			byte_s1    <= padding ? 8'd0 : occ.data.occupancy;
			byp_s1     <= advance && (x_q == x_s1);
			byp_top_s1 <= col.mid;
			byp_mid_s1 <= byte_s1;
		end
	end

	fcd_ram #(.Width(8), .Depth(MaxCols)) u_older (
		.clk   (clk),
		.we    (advance),
		.waddr (x_s1),
		.wdata (col.mid),
		.re    (accept),
		.raddr (x_q),
		.rdata (older_rd)
	);

	fcd_ram #(.Width(8), .Depth(MaxCols)) u_newer (
		.clk   (clk),
		.we    (advance),
		.waddr (x_s1),
		.wdata (byte_s1),
		.re    (accept),
		.raddr (x_q),
		.rdata (newer_rd)
	);

	always_comb begin
		col.valid   = valid_s1;
		col.top     = byp_s1 ? byp_top_s1 : older_rd;
		col.mid     = byp_s1 ? byp_mid_s1 : newer_rd;
		col.bot     = byte_s1;
		col.x       = x_s1;
		col.y       = y_s1;
		col.end_row = end_row_s1;
	end

endmodule

`default_nettype wire

/* sv/fcd_window.sv */
`default_nettype none

module fcd_window (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire fcd_pkg::cfg_t cfg,
	input  wire fcd_pkg::col_t col,
	input  wire logic          advance,
	output fcd_pkg::dec_t      dec
);

	import fcd_pkg::*;

	logic [2:0][7:0]      c1_q;
	logic [2:0][7:0]      c2_q;
	logic [2:0][2:0][7:0] win;
	logic [RowW-1:0]      cy;
	logic                 has_a;
	logic                 has_b;
	result_t              res_a;
	result_t              res_b;

	function automatic result_t decide(
		input logic [2:0][2:0][7:0] w,
		input cfg_t                 c,
		input logic [RowW-1:0]      ry,
		input logic [ColW-1:0]      rx,
		input logic                 at_end,
		input logic                 last
	);
		result_t    r;
		logic       top_ok;
		logic       mid_ok;
		logic       bot_ok;
		logic       left_ok;
		logic       ctr_ok;
		logic       right_ok;
		logic [1:0] cl;
		logic [1:0] cm;
		logic [7:0] hit;
		logic [3:0] cnt;
		top_ok   = (ry != '0) && (ry <= c.rows);
		mid_ok   = ry < c.rows;
		bot_ok   = (ry + RowW'(1)) < c.rows;
		left_ok  = (rx != '0) && (ColNW'(rx) <= c.cols);
		ctr_ok   = ColNW'(rx) < c.cols;
		right_ok = !at_end && ((ColNW'(rx) + ColNW'(1)) < c.cols);
		cl       = at_end ? 2'd1 : 2'd0;
		cm       = at_end ? 2'd2 : 2'd1;
		hit[0]   = top_ok && left_ok && (w[0][cl] == c.unknown_code);
		hit[1]   = top_ok && ctr_ok && (w[0][cm] == c.unknown_code);
		hit[2]   = top_ok && right_ok && (w[0][2] == c.unknown_code);
		hit[3]   = mid_ok && left_ok && (w[1][cl] == c.unknown_code);
		hit[4]   = mid_ok && right_ok && (w[1][2] == c.unknown_code);
		hit[5]   = bot_ok && left_ok && (w[2][cl] == c.unknown_code);
		hit[6]   = bot_ok && ctr_ok && (w[2][cm] == c.unknown_code);
		hit[7]   = bot_ok && right_ok && (w[2][2] == c.unknown_code);
		cnt      = 4'($countones(hit));
		r.cell_x        = CellW'(rx);
		r.cell_y        = CellW'(ry);
		r.unknown_count = cnt;
		r.is_frontier   = (w[1][cm] == c.free_code) && (cnt >= c.min_unknown);
		r.last_of_item  = last;
		r.frame_done    = (ry == c.rows - RowW'(1)) && (ColNW'(rx) == c.cols - ColNW'(1));
		return r;
	endfunction

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win[r][0] = c1_q[r];
			win[r][1] = c2_q[r];
		end
		win[0][2] = col.top;
		win[1][2] = col.mid;
		win[2][2] = col.bot;
	end

	assign cy    = col.y - RowW'(1);
	assign has_a = (col.y != '0) && (col.x != '0);
	assign has_b = (col.y != '0) && col.end_row;
	assign res_a = decide(win, cfg, cy, col.x - ColW'(1), 1'b0, !col.end_row);
	assign res_b = decide(win, cfg, cy, col.x, 1'b1, 1'b1);

	always_comb begin
		dec.count  = {1'b0, has_a} + {1'b0, has_b};
		dec.first  = has_a ? res_a : res_b;
		dec.second = res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
		end else if (advance) begin
			c1_q <= c2_q;
			c2_q <= {col.bot, col.mid, col.top};
		end
	end

endmodule

`default_nettype wire

/* sv/fcd_out_buf.sv */
`default_nettype none

module fcd_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire fcd_pkg::dec_t dec,
	input  wire logic          advance,
	output logic               can_take,
	fcd_res_if.source          result
);

	import fcd_pkg::*;

	logic [1:0] cnt_q;
	result_t    r0_q;
	result_t    r1_q;
	logic       pop;

	assign result.valid = cnt_q != 2'd0;
	assign result.data  = r0_q;
	assign pop          = result.valid && result.ready;
	assign can_take     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (advance) begin
			cnt_q <= dec.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			r0_q <= dec.first;
			r1_q <= dec.second;
		end else if (pop) begin
			r0_q <= r1_q;
		end
	end

endmodule

`default_nettype wire

/* sv/frontier_cell_detector.sv */
// Frontier cell detector for an occupancy grid streamed in raster order.
// occ channel: one occupancy byte per item, row after row; after the last grid
// row a padding row of grid_cols items pushes out the final decisions (the
// block counts positions itself, the flush bit is informational).
// result channel: one decided cell per result with its coordinates, the frontier
// flag and the count of unknown in-grid neighbours. Row 0 gives no results;
// the last item of a row gives two (one on a single-column grid), with
// last_of_item low on the first.
// Config port: write cfg_data into register cfg_index when cfg_wen is high;
// write only while no item is in flight.
// An accepted item is registered in the input stage; its results are loaded into
// the result buffer when that stage advances and are shown from then on.
// Throughput: one item per cycle while results are taken; an item that yields two
// results holds the input while the two-entry result buffer drains.
// Reset clears the row and column position, the window and the result buffer,
// and loads the register defaults. The line stores are not cleared.
// When the receiver stalls, results stay in the buffer, then the input stage
// fills and occ.ready drops; nothing is lost.
`default_nettype none

module frontier_cell_detector (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	fcd_occ_if.sink                           occ,
	fcd_res_if.source                         result,
	input  wire logic                         cfg_wen,
	input  wire logic [fcd_pkg::IdxW-1:0]     cfg_index,
	input  wire logic [fcd_pkg::CfgW-1:0]     cfg_data
);

	import fcd_pkg::*;

	cfg_t cfg_q;
	col_t col;
	dec_t dec;
	logic can_take;
	logic advance;

	assign advance = col.valid && can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows         <= RowW'(RstRows);
			cfg_q.cols         <= ColNW'(RstCols);
			cfg_q.free_code    <= 8'd255;
			cfg_q.unknown_code <= 8'd127;
			cfg_q.min_unknown  <= 4'd2;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				RegGridRows: begin
					if (cfg_data == '0) begin
						cfg_q.rows <= RowW'(1);
					end else if (32'(cfg_data) > MaxRows) begin
						cfg_q.rows <= RowW'(MaxRows);
					end else begin
						cfg_q.rows <= RowW'(cfg_data);
					end
				end
				RegGridCols: begin
					if (cfg_data == '0) begin
						cfg_q.cols <= ColNW'(1);
					end else if (32'(cfg_data) > MaxCols) begin
						cfg_q.cols <= ColNW'(MaxCols);
					end else begin
						cfg_q.cols <= ColNW'(cfg_data);
					end
				end
				RegFreeCode:   cfg_q.free_code    <= cfg_data[7:0];
				RegUnknown:    cfg_q.unknown_code <= cfg_data[7:0];
				RegMinUnknown: cfg_q.min_unknown  <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	fcd_line_buf u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.occ     (occ),
		.cfg     (cfg_q),
		.advance (advance),
		.col     (col)
	);

	fcd_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.col     (col),
		.advance (advance),
		.dec     (dec)
	);

	fcd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.dec      (dec),
		.advance  (advance),
		.can_take (can_take),
		.result   (result)
	);

endmodule

`default_nettype wire

/* sv/fcd_checker.sv */
`default_nettype none

module fcd_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             occ_valid,
	input wire logic             occ_ready,
	input wire logic             res_valid,
	input wire logic             res_ready,
	input wire fcd_pkg::result_t res_data
);

	import fcd_pkg::*;

	logic occ_seen;

	assign occ_seen = occ_valid;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result changed while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> occ_ready || !occ_seen || occ_ready)
		else $error("input blocked with empty result buffer");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_data.last_of_item |=> res_valid)
		else $error("second result of an item missing");

endmodule

bind frontier_cell_detector fcd_checker u_fcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.occ_valid (occ.valid),
	.occ_ready (occ.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);

`default_nettype wire
